// ===== hdl/ecgrh_pkg.sv =====
// ----------------------------------------------------------------------------
// ecgrh_pkg
// Shared constants and types of the ECG R-peak and heart-rate block.
// ----------------------------------------------------------------------------
package ecgrh_pkg;

   // fixed-point format of the filter state
   localparam int SAMPLE_BITS   = 12;
   localparam int FRACTION_BITS = 16;
   localparam int VALUE_BITS    = SAMPLE_BITS + FRACTION_BITS;
   localparam int GAIN_BITS     = 16;
   localparam int PROD_BITS     = VALUE_BITS + GAIN_BITS;

   localparam int THRESH_BITS = 12;
   localparam int REFR_BITS   = 10;
   localparam int SCALE_BITS  = 16;
   localparam int COUNT_BITS  = 16;
   localparam int RATE_BITS   = 8;
   localparam int ROW_BITS    = 6;
   localparam int DIV_BITS    = 16;

   localparam logic [VALUE_BITS-1:0] VALUE_RESET = VALUE_BITS'(2048) << FRACTION_BITS;

   // register reset values
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = 16'd26214;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd2300;
   localparam logic [REFR_BITS-1:0]   REFR_RESET   = 10'd40;
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET  = 16'd12000;
   localparam logic [RATE_BITS-1:0]   RMIN_RESET   = 8'd30;
   localparam logic [RATE_BITS-1:0]   RMAX_RESET   = 8'd220;

   // register map
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [2:0] REG_GAIN   = 3'd0;
   localparam logic [2:0] REG_THRESH = 3'd1;
   localparam logic [2:0] REG_REFR   = 3'd2;
   localparam logic [2:0] REG_SCALE  = 3'd3;
   localparam logic [2:0] REG_RMIN   = 3'd4;
   localparam logic [2:0] REG_RMAX   = 3'd5;

   // display row: 90 - whole/45, whole/45 as (whole*2913) >> 17
   localparam int ROW_PROD_BITS = 24;
   localparam int ROW_SHIFT     = 17;
   localparam int ROW_Q_BITS    = ROW_PROD_BITS - ROW_SHIFT;
   localparam logic [SAMPLE_BITS-1:0] ROW_RECIP = 12'd2913;
   localparam logic [ROW_Q_BITS-1:0]  ROW_BASE  = 7'd90;
   localparam logic [ROW_Q_BITS-1:0]  ROW_Q_LOW = 7'd37;
   localparam logic [ROW_Q_BITS-1:0]  ROW_Q_TOP = 7'd79;
   localparam logic [ROW_BITS-1:0]    ROW_MIN   = 6'd11;
   localparam logic [ROW_BITS-1:0]    ROW_MAX   = 6'd53;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] whole;
      logic                   peak;
      logic                   need_rate;
      logic [COUNT_BITS-1:0]  interval;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/ecgrh_front.sv =====
// ----------------------------------------------------------------------------
// ecgrh_front
// Low-pass filter and R-peak test; hands one job per sample to the queue.
// ----------------------------------------------------------------------------
module ecgrh_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [ecgrh_pkg::SAMPLE_BITS-1:0]     req_sample,
   input  logic [ecgrh_pkg::GAIN_BITS-1:0]       cfg_gain,
   input  logic [ecgrh_pkg::THRESH_BITS-1:0]     cfg_thresh,
   input  logic [ecgrh_pkg::REFR_BITS-1:0]       cfg_refr,
   input  ecgrh_pkg::queue_status_type           q_status,
   output logic                                  q_push,
   output ecgrh_pkg::job_type                    q_data
);
   import ecgrh_pkg::*;

   logic [VALUE_BITS-1:0] filter_ff, filter_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [VALUE_BITS-1:0] older_ff, older_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  seen_ff, seen_in;
   logic                  busy_ff, busy_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic                  up_ff, up_in;

   logic                  accept;
   logic [VALUE_BITS-1:0] x_value;
   logic [VALUE_BITS-1:0] diff;
   logic [VALUE_BITS-1:0] step;
   logic [VALUE_BITS-1:0] y_new;
   logic [COUNT_BITS-1:0] count_inc;
   logic [COUNT_BITS-1:0] interval;
   logic                  peak;

   assign req_stall = busy_ff;
   assign accept    = req_valid & ~busy_ff;

   assign x_value = {req_sample, FRACTION_BITS'(0)};
   assign up_in   = (x_value >= filter_ff);
   assign diff    = up_in ? (x_value - filter_ff) : (filter_ff - x_value);
   assign prod_in = PROD_BITS'(diff) * PROD_BITS'(cfg_gain);

   assign step  = prod_ff[PROD_BITS-1:GAIN_BITS];
   assign y_new = up_ff ? (filter_ff + step) : (filter_ff - step);

   // counter saturates at all ones
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_BITS'(1);
   assign interval  = count_inc - COUNT_BITS'(1);

   assign peak = (count_inc > COUNT_BITS'(cfg_refr)) &&
                 (prev_ff > older_ff) && (prev_ff > y_new) &&
                 (prev_ff > {cfg_thresh, FRACTION_BITS'(0)});

   assign q_push           = busy_ff & ~q_status.full;
   assign q_data.whole     = y_new[VALUE_BITS-1:FRACTION_BITS];
   assign q_data.peak      = peak;
   assign q_data.need_rate = peak & seen_ff & (interval != '0);
   assign q_data.interval  = interval;

   always_comb begin
      filter_in = filter_ff;
      prev_in   = prev_ff;
      older_in  = older_ff;
      count_in  = count_ff;
      seen_in   = seen_ff;
      busy_in   = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end
      if (q_push) begin
         filter_in = y_new;
         prev_in   = y_new;
         older_in  = prev_ff;
         count_in  = peak ? COUNT_BITS'(1) : count_inc;
         seen_in   = seen_ff | peak;
         busy_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_ff <= VALUE_RESET;
         prev_ff   <= VALUE_RESET;
         older_ff  <= VALUE_RESET;
         count_ff  <= '0;
         seen_ff   <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         filter_ff <= filter_in;
         prev_ff   <= prev_in;
         older_ff  <= older_in;
         count_ff  <= count_in;
         seen_ff   <= seen_in;
         busy_ff   <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prod_ff <= prod_in;
         up_ff   <= up_in;
      end
   end

endmodule

// ===== hdl/ecgrh_queue.sv =====
// ----------------------------------------------------------------------------
// ecgrh_queue
// Small job queue between the filter front and the rate back end.
// ----------------------------------------------------------------------------
module ecgrh_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  ecgrh_pkg::job_type           push_data,
   input  logic                         pop,
   output ecgrh_pkg::job_type           head,
   output ecgrh_pkg::queue_status_type  status
);
   import ecgrh_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   job_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/ecgrh_div.sv =====
// ----------------------------------------------------------------------------
// ecgrh_div
// Restoring divider, one quotient bit per cycle, shared by rate and mean.
// ----------------------------------------------------------------------------
module ecgrh_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ecgrh_pkg::DIV_BITS-1:0]    dividend,
   input  logic [ecgrh_pkg::DIV_BITS-1:0]    divisor,
   output ecgrh_pkg::div_status_type         status,
   output logic [ecgrh_pkg::DIV_BITS-1:0]    quotient
);
   import ecgrh_pkg::*;

   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   logic [DIV_BITS:0]    rem_ff, rem_in;
   logic [DIV_BITS-1:0]  quo_ff, quo_in;
   logic [DIV_BITS-1:0]  dsr_ff, dsr_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_BITS:0]    shifted;
   logic                 fits;

   assign shifted = {rem_ff[DIV_BITS-1:0], quo_ff[DIV_BITS-1]};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_BITS'(DIV_BITS);
      end else if (cnt_ff != '0) begin
         rem_in  = fits ? (shifted - {1'b0, dsr_ff}) : shifted;
         quo_in  = {quo_ff[DIV_BITS-2:0], fits};
         cnt_in  = cnt_ff - CNT_BITS'(1);
         done_in = (cnt_ff == CNT_BITS'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

// ===== hdl/ecgrh_back.sv =====
// ----------------------------------------------------------------------------
// ecgrh_back
// Heart-rate back end: interval to rate, rate history mean, display row and
// the result register.
// ----------------------------------------------------------------------------
module ecgrh_back #(
   parameter int RATE_WINDOW = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ecgrh_pkg::job_type                    q_head,
   input  ecgrh_pkg::queue_status_type           q_status,
   output logic                                  q_pop,
   input  logic [ecgrh_pkg::SCALE_BITS-1:0]      cfg_scale,
   input  logic [ecgrh_pkg::RATE_BITS-1:0]       cfg_rmin,
   input  logic [ecgrh_pkg::RATE_BITS-1:0]       cfg_rmax,
   output logic                                  div_start,
   output logic [ecgrh_pkg::DIV_BITS-1:0]        div_dividend,
   output logic [ecgrh_pkg::DIV_BITS-1:0]        div_divisor,
   input  ecgrh_pkg::div_status_type             div_status,
   input  logic [ecgrh_pkg::DIV_BITS-1:0]        div_quotient,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ecgrh_pkg::SAMPLE_BITS-1:0]     rsp_filtered_sample,
   output logic                                  rsp_peak_found,
   output logic [ecgrh_pkg::RATE_BITS-1:0]       rsp_heart_rate,
   output logic [ecgrh_pkg::ROW_BITS-1:0]        rsp_display_row
);
   import ecgrh_pkg::*;

   localparam int POS_BITS  = (RATE_WINDOW > 1) ? $clog2(RATE_WINDOW) : 1;
   localparam int FILL_BITS = $clog2(RATE_WINDOW + 1);
   localparam int SUM_BITS  = $clog2(RATE_WINDOW * 255 + 1);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_RATE = 4'b0010,
      ST_AVG  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [ROW_PROD_BITS-1:0] row_prod_ff, row_prod_in;
   logic [RATE_BITS-1:0]    hist_ff [RATE_WINDOW];
   logic [POS_BITS-1:0]     wpos_ff, wpos_in;
   logic [FILL_BITS-1:0]    fill_ff, fill_in;
   logic [SUM_BITS-1:0]     sum_ff, sum_in;
   logic [RATE_BITS-1:0]    avg_ff, avg_in;
   logic                    hist_we;

   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0]  out_whole_ff;
   logic                    out_peak_ff;
   logic [RATE_BITS-1:0]    out_rate_ff;
   logic [ROW_BITS-1:0]     out_row_ff;
   logic                    out_load;

   logic                    in_range;
   logic [RATE_BITS-1:0]    new_rate;
   logic [ROW_Q_BITS-1:0]   row_q;
   logic [ROW_Q_BITS-1:0]   row_diff;
   logic [ROW_BITS-1:0]     row_value;

   assign new_rate = div_quotient[RATE_BITS-1:0];
   assign in_range = (div_quotient >= DIV_BITS'(cfg_rmin)) &&
                     (div_quotient <= DIV_BITS'(cfg_rmax));

   // running sum over the whole ring; unused entries stay zero
   assign sum_in  = sum_ff + SUM_BITS'(new_rate) - SUM_BITS'(hist_ff[wpos_ff]);
   assign fill_in = (fill_ff == FILL_BITS'(RATE_WINDOW)) ? fill_ff : fill_ff + FILL_BITS'(1);
   assign wpos_in = (wpos_ff == POS_BITS'(RATE_WINDOW - 1)) ? '0 : wpos_ff + POS_BITS'(1);

   assign row_prod_in = ROW_PROD_BITS'(q_head.whole) * ROW_PROD_BITS'(ROW_RECIP);
   assign row_q       = row_prod_ff[ROW_PROD_BITS-1:ROW_SHIFT];
   assign row_diff    = ROW_BASE - row_q;
   assign row_value   = (row_q < ROW_Q_LOW) ? ROW_MAX :
                        (row_q > ROW_Q_TOP) ? ROW_MIN : row_diff[ROW_BITS-1:0];

   assign div_dividend = (state_ff == ST_IDLE) ? DIV_BITS'(cfg_scale) : DIV_BITS'(sum_in);
   assign div_divisor  = (state_ff == ST_IDLE) ? DIV_BITS'(q_head.interval)
                                               : DIV_BITS'(fill_in);

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      avg_in    = avg_ff;
      q_pop     = 1'b0;
      div_start = 1'b0;
      hist_we   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               job_in = q_head;
               if (q_head.need_rate) begin
                  div_start = 1'b1;
                  state_in  = ST_RATE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RATE: begin
            if (div_status.done) begin
               if (in_range) begin
                  hist_we   = 1'b1;
                  div_start = 1'b1;
                  state_in  = ST_AVG;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_AVG: begin
            if (div_status.done) begin
               avg_in   = new_rate;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign out_valid_in = out_load | (out_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wpos_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < RATE_WINDOW; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         avg_ff       <= avg_in;
         out_valid_ff <= out_valid_in;
         if (hist_we) begin
            hist_ff[wpos_ff] <= new_rate;
            wpos_ff          <= wpos_in;
            fill_ff          <= fill_in;
            sum_ff           <= sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      if (q_pop) begin
         row_prod_ff <= row_prod_in;
      end
      if (out_load) begin
         out_whole_ff <= job_ff.whole;
         out_peak_ff  <= job_ff.peak;
         out_rate_ff  <= avg_ff;
         out_row_ff   <= row_value;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_filtered_sample = out_whole_ff;
   assign rsp_peak_found      = out_peak_ff;
   assign rsp_heart_rate      = out_rate_ff;
   assign rsp_display_row     = out_row_ff;

endmodule

// ===== hdl/ecg_rpeak_heart_rate.sv =====
// ----------------------------------------------------------------------------
// ecg_rpeak_heart_rate
// ECG low-pass filter, R-peak detector and averaged heart rate.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  sample
//  rsp_      out        rsp_valid/rsp_stall  filtered_sample, peak_found,
//                                            heart_rate, display_row
//  csr_      in         apb psel/penable     six config registers at 4*i
//
//  front end takes a sample, multiplies, then updates; it takes the next only
//  after that job is pushed, which needs room in the queue. the back end pops
//  a job, makes one division for a rate that is rejected and two for one that
//  enters the history; each is a load and 16 steps on the one shared divider.
//  reset is synchronous and restores the filter to mid-scale and the registers
//  to their defaults. a stalled result is held in the output register while
//  the back end works on the next queued transaction.
// ----------------------------------------------------------------------------
module ecg_rpeak_heart_rate #(
   parameter int RATE_WINDOW = 4
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ecgrh_pkg::SAMPLE_BITS-1:0]      req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ecgrh_pkg::SAMPLE_BITS-1:0]      rsp_filtered_sample,
   output logic                                   rsp_peak_found,
   output logic [ecgrh_pkg::RATE_BITS-1:0]        rsp_heart_rate,
   output logic [ecgrh_pkg::ROW_BITS-1:0]         rsp_display_row,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ecgrh_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [ecgrh_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [ecgrh_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import ecgrh_pkg::*;

   logic [GAIN_BITS-1:0]   gain_ff;
   logic [THRESH_BITS-1:0] thresh_ff;
   logic [REFR_BITS-1:0]   refr_ff;
   logic [SCALE_BITS-1:0]  scale_ff;
   logic [RATE_BITS-1:0]   rmin_ff;
   logic [RATE_BITS-1:0]   rmax_ff;

   logic                   csr_write;
   logic [2:0]             csr_index;

   logic                   q_push;
   logic                   q_pop;
   job_type                q_data;
   job_type                q_head;
   queue_status_type       q_status;

   logic                   div_start;
   logic [DIV_BITS-1:0]    div_dividend;
   logic [DIV_BITS-1:0]    div_divisor;
   logic [DIV_BITS-1:0]    div_quotient;
   div_status_type         div_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         thresh_ff <= THRESH_RESET;
         refr_ff   <= REFR_RESET;
         scale_ff  <= SCALE_RESET;
         rmin_ff   <= RMIN_RESET;
         rmax_ff   <= RMAX_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_GAIN:   gain_ff   <= csr_pwdata[GAIN_BITS-1:0];
            REG_THRESH: thresh_ff <= csr_pwdata[THRESH_BITS-1:0];
            REG_REFR:   refr_ff   <= csr_pwdata[REFR_BITS-1:0];
            REG_SCALE:  scale_ff  <= csr_pwdata[SCALE_BITS-1:0];
            REG_RMIN:   rmin_ff   <= csr_pwdata[RATE_BITS-1:0];
            REG_RMAX:   rmax_ff   <= csr_pwdata[RATE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_GAIN:   csr_prdata = CSR_DATA_BITS'(gain_ff);
         REG_THRESH: csr_prdata = CSR_DATA_BITS'(thresh_ff);
         REG_REFR:   csr_prdata = CSR_DATA_BITS'(refr_ff);
         REG_SCALE:  csr_prdata = CSR_DATA_BITS'(scale_ff);
         REG_RMIN:   csr_prdata = CSR_DATA_BITS'(rmin_ff);
         REG_RMAX:   csr_prdata = CSR_DATA_BITS'(rmax_ff);
         default:    csr_prdata = '0;
      endcase
   end

   ecgrh_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .cfg_gain   (gain_ff),
      .cfg_thresh (thresh_ff),
      .cfg_refr   (refr_ff),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   ecgrh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   ecgrh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quotient)
   );

   ecgrh_back #(
      .RATE_WINDOW (RATE_WINDOW)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .q_head              (q_head),
      .q_status            (q_status),
      .q_pop               (q_pop),
      .cfg_scale           (scale_ff),
      .cfg_rmin            (rmin_ff),
      .cfg_rmax            (rmax_ff),
      .div_start           (div_start),
      .div_dividend        (div_dividend),
      .div_divisor         (div_divisor),
      .div_status          (div_status),
      .div_quotient        (div_quotient),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_filtered_sample (rsp_filtered_sample),
      .rsp_peak_found      (rsp_peak_found),
      .rsp_heart_rate      (rsp_heart_rate),
      .rsp_display_row     (rsp_display_row)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("job pushed into a full queue");

   a_queue_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("job popped from an empty queue");

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider restarted while busy");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_display_row >= ROW_MIN) && (rsp_display_row <= ROW_MAX))
      else $error("display row out of range");

endmodule
